// File: rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Types and codes shared by the pusher fire sequencer modules.
// ----------------------------------------------------------------------------
package pfs_pkg;

    typedef enum logic [2:0] {
        SQ_IDLE   = 3'd0,
        SQ_A2B    = 3'd1,
        SQ_DETECT = 3'd2,
        SQ_BREADY = 3'd3,
        SQ_B2C    = 3'd4,
        SQ_C2L    = 3'd5
    } seq_state_t;

    typedef enum logic [1:0] {
        PT_L = 2'd0,
        PT_A = 2'd1,
        PT_B = 2'd2,
        PT_C = 2'd3
    } point_t;

    typedef enum logic [1:0] {
        FS_NOT_READY = 2'd0,
        FS_READY     = 2'd1,
        FS_END_B     = 2'd2,
        FS_END_C     = 2'd3
    } fire_stat_t;

    typedef enum logic [2:0] {
        REG_CURRENT_THRESHOLD = 3'd0,
        REG_CONFIRM_TICKS     = 3'd1,
        REG_DEBOUNCE_MS       = 3'd2,
        REG_MOVE_A_TO_B_MS    = 3'd3,
        REG_DETECT_TIMEOUT_MS = 3'd4,
        REG_MOVE_B_TO_C_MS    = 3'd5,
        REG_MOVE_C_TO_L_MS    = 3'd6
    } reg_index_t;

    localparam int CUR_W    = 16;
    localparam int THR_W    = 15;
    localparam int CNT_W    = 3;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 16;

endpackage

// File: rtl/pusher_fire_sequencer.sv
// ----------------------------------------------------------------------------
// pusher_fire_sequencer
// Fire debounce, pusher stroke sequencer, shot confirm and load staging.
// ----------------------------------------------------------------------------
// Output: a result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the output register frees up when taken,
// so s_tready stays high while the result register is empty or being read.
// Reset: aresetn low clears sequencer state, timers and the result register
// valid, and loads every configuration register with its default value.
module pusher_fire_sequencer
    import pfs_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] now_ms, [32] fire_raw, [48:33] current_upper_left,
    // [64:49] current_upper_right, [80:65] current_lower, [81] load_done
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] target_point, [2] move_command, [3] load_request, [5:4] stroke_point,
    // [7:6] fire_status, [8] shot_flag, [11:9] sequence_state
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] confirm_reg;
    logic [MS_W-1:0]  debounce_reg;
    logic [MS_W-1:0]  a2b_reg;
    logic [MS_W-1:0]  detect_reg;
    logic [MS_W-1:0]  b2c_reg;
    logic [MS_W-1:0]  c2l_reg;

    seq_state_t       state_reg, state_next;
    logic [TIME_BITS-1:0] state_start_reg, state_start_next;
    logic [TIME_BITS-1:0] deb_start_reg, deb_start_next;
    logic             deb_armed_reg, deb_armed_next;
    logic             prev_fire_reg;
    point_t           stroke_reg, stroke_next;
    point_t           target_reg, target_next;
    fire_stat_t       fstat_reg, fstat_next;
    logic             shot_reg, shot_next;
    logic             load_req_reg, load_req_next;
    logic             move;
    logic             pulse;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    logic                    accept;
    logic [TIME_BITS-1:0]    now_t;
    logic                    fire;
    logic signed [CUR_W-1:0] cur_ul, cur_ur, cur_lo;
    logic                    done;
    logic [TIME_BITS-1:0]    state_elapsed, deb_elapsed;
    logic                    confirmed;

    assign now_t  = s_tdata[TIME_BITS-1:0];
    assign fire   = s_tdata[32];
    assign cur_ul = $signed(s_tdata[48:33]);
    assign cur_ur = $signed(s_tdata[64:49]);
    assign cur_lo = $signed(s_tdata[80:65]);
    assign done   = s_tdata[81];

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    assign state_elapsed = now_t - state_start_reg;
    assign deb_elapsed   = now_t - deb_start_reg;

    pfs_shot_detect u_shot (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (accept && (state_reg == SQ_DETECT)),
        .cur_ul        (cur_ul),
        .cur_ur        (cur_ur),
        .cur_lo        (cur_lo),
        .threshold     (thr_reg),
        .confirm_ticks (confirm_reg),
        .confirmed     (confirmed)
    );

    always_comb begin
        deb_armed_next = deb_armed_reg;
        deb_start_next = deb_start_reg;
        pulse          = 1'b0;
        if (fire) begin
            if (!prev_fire_reg) begin
                deb_start_next = now_t;
                deb_armed_next = 1'b1;
            end else if (deb_armed_reg && (deb_elapsed >= TIME_BITS'(debounce_reg))) begin
                pulse          = 1'b1;
                deb_armed_next = 1'b0;
            end
        end else begin
            deb_armed_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (stroke_reg == PT_A && fstat_reg == FS_READY && pulse)
                    state_next = SQ_A2B;
            end
            SQ_A2B: begin
                if (state_elapsed >= TIME_BITS'(a2b_reg))
                    state_next = SQ_DETECT;
            end
            SQ_DETECT: begin
                if (confirmed)
                    state_next = SQ_BREADY;
                else if (state_elapsed >= TIME_BITS'(detect_reg))
                    state_next = SQ_B2C;
            end
            SQ_BREADY: begin
                if (pulse)
                    state_next = SQ_B2C;
            end
            SQ_B2C: begin
                if (state_elapsed >= TIME_BITS'(b2c_reg))
                    state_next = SQ_C2L;
            end
            SQ_C2L: begin
                if (state_elapsed >= TIME_BITS'(c2l_reg))
                    state_next = SQ_IDLE;
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb begin
        stroke_next      = stroke_reg;
        target_next      = target_reg;
        fstat_next       = fstat_reg;
        shot_next        = shot_reg;
        load_req_next    = load_req_reg;
        state_start_next = state_start_reg;
        move             = 1'b0;
        case (state_reg)
            SQ_IDLE: begin
                if (state_next == SQ_A2B) begin
                    target_next      = PT_B;
                    move             = 1'b1;
                    state_start_next = now_t;
                end
            end
            SQ_A2B: begin
                if (state_next == SQ_DETECT) begin
                    stroke_next      = PT_B;
                    state_start_next = now_t;
                end
            end
            SQ_DETECT: begin
                if (confirmed) begin
                    shot_next  = 1'b1;
                    fstat_next = FS_END_B;
                end else if (state_next == SQ_B2C) begin
                    target_next      = PT_C;
                    move             = 1'b1;
                    state_start_next = now_t;
                end
            end
            SQ_BREADY: begin
                if (pulse) begin
                    target_next      = PT_C;
                    move             = 1'b1;
                    state_start_next = now_t;
                end
            end
            SQ_B2C: begin
                if (state_next == SQ_C2L) begin
                    stroke_next      = PT_C;
                    fstat_next       = FS_END_C;
                    target_next      = PT_L;
                    move             = 1'b1;
                    state_start_next = now_t;
                end
            end
            SQ_C2L: begin
                if (state_next == SQ_IDLE) begin
                    stroke_next      = PT_L;
                    shot_next        = 1'b0;
                    fstat_next       = FS_READY;
                    state_start_next = '0;
                end
            end
            default: state_start_next = '0;
        endcase

        if (stroke_next == PT_L)
            load_req_next = 1'b1;
        if (done) begin
            load_req_next = 1'b0;
            target_next   = PT_A;
            move          = 1'b1;
            stroke_next   = PT_A;
            fstat_next    = FS_READY;
        end

        m_data_next = {4'b0000, state_next, shot_next, fstat_next, stroke_next,
                       load_req_next, move, target_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SQ_IDLE;
            state_start_reg <= '0;
            deb_start_reg   <= '0;
            deb_armed_reg   <= 1'b0;
            prev_fire_reg   <= 1'b0;
            stroke_reg      <= PT_L;
            target_reg      <= PT_L;
            fstat_reg       <= FS_NOT_READY;
            shot_reg        <= 1'b0;
            load_req_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                state_reg       <= state_next;
                state_start_reg <= state_start_next;
                deb_start_reg   <= deb_start_next;
                deb_armed_reg   <= deb_armed_next;
                prev_fire_reg   <= fire;
                stroke_reg      <= stroke_next;
                target_reg      <= target_next;
                fstat_reg       <= fstat_next;
                shot_reg        <= shot_next;
                load_req_reg    <= load_req_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept)
            m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THR_W'(2000);
            confirm_reg  <= CNT_W'(5);
            debounce_reg <= MS_W'(300);
            a2b_reg      <= MS_W'(1000);
            detect_reg   <= MS_W'(1000);
            b2c_reg      <= MS_W'(1000);
            c2l_reg      <= MS_W'(1000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CURRENT_THRESHOLD: thr_reg      <= cfg_data[THR_W-1:0];
                REG_CONFIRM_TICKS:     confirm_reg  <= cfg_data[CNT_W-1:0];
                REG_DEBOUNCE_MS:       debounce_reg <= cfg_data;
                REG_MOVE_A_TO_B_MS:    a2b_reg      <= cfg_data;
                REG_DETECT_TIMEOUT_MS: detect_reg   <= cfg_data;
                REG_MOVE_B_TO_C_MS:    b2c_reg      <= cfg_data;
                REG_MOVE_C_TO_L_MS:    c2l_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_IDLE) |-> (state_start_reg == '0))
        else $error("idle with running state timer");

    a_shot_in_late_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        shot_reg |-> (state_reg == SQ_BREADY || state_reg == SQ_B2C
                      || state_reg == SQ_C2L))
        else $error("shot flag set outside post-detect phases");

endmodule

// File: rtl/pfs_shot_detect.sv
// ----------------------------------------------------------------------------
// pfs_shot_detect
// Wheel current compare and saturating over-threshold run counter.
// ----------------------------------------------------------------------------
module pfs_shot_detect
    import pfs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic signed [CUR_W-1:0]  cur_ul,
    input  logic signed [CUR_W-1:0]  cur_ur,
    input  logic signed [CUR_W-1:0]  cur_lo,
    input  logic [THR_W-1:0]         threshold,
    input  logic [CNT_W-1:0]         confirm_ticks,
    output logic                     confirmed
);

    logic [CNT_W-1:0]        over_count_reg;
    logic [CNT_W-1:0]        over_count_next;
    logic signed [CUR_W+1:0] sum;
    logic [THR_W+1:0]        mean_limit;
    logic signed [CUR_W-1:0] thr_s;
    logic                    over;
    logic [CNT_W:0]          run;

    // mean = trunc(sum / 3) > thr  <=>  sum >= 3 * thr + 3  (thr is non-negative)
    assign sum = (CUR_W+2)'(cur_ul) + (CUR_W+2)'(cur_ur) + (CUR_W+2)'(cur_lo);
    assign mean_limit = {2'b00, threshold} + {1'b0, threshold, 1'b0} + (THR_W+2)'(3);
    assign thr_s = $signed({1'b0, threshold});

    assign over = (sum >= $signed({1'b0, mean_limit})) || (cur_lo > thr_s)
                  || (cur_ul > thr_s) || (cur_ur > thr_s);

    assign run = over ? ({1'b0, over_count_reg} + (CNT_W+1)'(1)) : '0;
    assign confirmed = (run >= {1'b0, confirm_ticks});
    assign over_count_next = confirmed ? confirm_ticks : run[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            over_count_reg <= '0;
        end else if (en) begin
            over_count_reg <= over_count_next;
        end
    end

endmodule
